### rtl/lsmx_pkg.sv
// ----------------------------------------------------------------------------
// lsmx_pkg: shared types and constants for the load/store multiple expander
// Opcode and phase encodings, field widths and the command and result words
// passed between the expander's modules.
// ----------------------------------------------------------------------------
package lsmx_pkg;

   localparam int NUM_REGS_DEF   = 32;
   localparam int WORD_BYTES_DEF = 4;

   localparam int REG_W   = 5;
   localparam int OFS_W   = 9;
   localparam int MASK_W  = 4;
   localparam int EXTRA_N = 4;
   localparam int IDX_W   = 2;

   // extra registers sit at the top of the file: fp, gp, lp, sp
   localparam logic [REG_W-1:0] REG_SP = 5'd31;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_STORE = 2'd1,
      OP_ADD   = 2'd2
   } op_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RANGE,
      PH_EXTRA,
      PH_MODIFY
   } phase_type;

   typedef struct packed {
      logic              is_store;
      logic              after_mode;
      logic              decrement;
      logic              modify_base;
      logic              range_none;
      logic [REG_W-1:0]  first_reg;
      logic [REG_W-1:0]  last_reg;
      logic [MASK_W-1:0] enable_mask;
      logic [REG_W-1:0]  base_reg;
   } cmd_type;

   typedef struct packed {
      op_kind_type      op_kind;
      logic [REG_W-1:0] data_reg;
      logic [REG_W-1:0] addr_reg;
      logic [OFS_W-1:0] byte_offset;
      logic             last;
   } item_type;

endpackage

### rtl/load_store_multiple_expander_core.sv
// ----------------------------------------------------------------------------
// Flow: the request word is taken into the sequencer state, then each empty part
// (range or extra registers) passes through its own state; after that one result
// word per cycle is registered while rsp_tready is high. A new request word is
// taken only when the sequencer has emitted every word of the previous instruction.
// Reset: synchronous, active high; clears the sequencer phase, access count and output valid.
// ----------------------------------------------------------------------------
// load_store_multiple_expander_core: load/store multiple expander top level
// Takes one multiple-word instruction and emits its single-word accesses and
// the optional base update through a registered result channel.
// ----------------------------------------------------------------------------
module load_store_multiple_expander_core
   import lsmx_pkg::*;
#(
   parameter int NUM_REGS   = NUM_REGS_DEF,
   parameter int WORD_BYTES = WORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // after_mode, decrement, modify_base, range_none, first_reg[4:0],
   // last_reg[4:0], enable_mask[3:0], base_reg[4:0], zero pad
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,   // is_store
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data_reg[4:0], addr_reg[4:0], byte_offset[8:0], zero pad
   output logic [23:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // op_kind
   output logic        rsp_tlast
);

   cmd_type  cmd;
   item_type item;
   logic     idle;
   logic     emit;
   logic     out_free;
   logic     start;

   logic     rsp_valid_ff, rsp_valid_in;
   item_type rsp_item_ff, rsp_item_in;

   assign cmd.is_store    = req_tuser;
   assign cmd.after_mode  = req_tdata[0];
   assign cmd.decrement   = req_tdata[1];
   assign cmd.modify_base = req_tdata[2];
   assign cmd.range_none  = req_tdata[3];
   assign cmd.first_reg   = req_tdata[8:4];
   assign cmd.last_reg    = req_tdata[13:9];
   assign cmd.enable_mask = req_tdata[17:14];
   assign cmd.base_reg    = req_tdata[22:18];

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   // output slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;

   lsmx_sequencer #(
      .NUM_REGS   (NUM_REGS),
      .WORD_BYTES (WORD_BYTES)
   ) u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cmd      (cmd),
      .out_free (out_free),
      .idle     (idle),
      .emit     (emit),
      .item     (item)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_item_in  = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.op_kind;
   assign rsp_tdata  = {5'd0, rsp_item_ff.byte_offset, rsp_item_ff.addr_reg,
                        rsp_item_ff.data_reg};
   assign rsp_tlast  = rsp_item_ff.last;

endmodule

### rtl/lsmx_offset_unit.sv
// ----------------------------------------------------------------------------
// lsmx_offset_unit: byte offset generator
// Forms WORD_BYTES * count, plus WORD_BYTES when first_en is set, applies the
// direction and saturates the result into the signed offset field.
// ----------------------------------------------------------------------------
module lsmx_offset_unit
   import lsmx_pkg::*;
#(
   parameter int NUM_REGS   = NUM_REGS_DEF,
   parameter int WORD_BYTES = WORD_BYTES_DEF
) (
   input  logic                                  first_en,
   input  logic                                  neg,
   input  logic [$clog2(NUM_REGS+EXTRA_N+1)-1:0] count,
   output logic [OFS_W-1:0]                      offset
);

   localparam int MAX_ACC = NUM_REGS + EXTRA_N;
   localparam int MAG_W   = $clog2(WORD_BYTES * (MAX_ACC + 1) + 1);
   localparam int EXT_W   = (MAG_W > OFS_W + 1) ? MAG_W : OFS_W + 1;
   localparam logic [EXT_W-1:0] POS_MAX = EXT_W'(2 ** (OFS_W - 1) - 1);
   localparam logic [EXT_W-1:0] NEG_MAX = EXT_W'(2 ** (OFS_W - 1));

   logic [EXT_W-1:0] mag;
   logic [EXT_W-1:0] sat;

   always_comb begin
      mag = (first_en ? EXT_W'(WORD_BYTES) : '0) + EXT_W'(count) * EXT_W'(WORD_BYTES);
      if (neg) begin
         sat    = (mag > NEG_MAX) ? NEG_MAX : mag;
         offset = OFS_W'(EXT_W'(0) - sat);
      end else begin
         sat    = (mag > POS_MAX) ? POS_MAX : mag;
         offset = OFS_W'(sat);
      end
   end

endmodule

### rtl/lsmx_sequencer.sv
// ----------------------------------------------------------------------------
// lsmx_sequencer: access sequencer
// Walks the register range and the extra registers in the direction's order,
// one access per cycle while out_free is high, then the optional base update.
// ----------------------------------------------------------------------------
module lsmx_sequencer
   import lsmx_pkg::*;
#(
   parameter int NUM_REGS   = NUM_REGS_DEF,
   parameter int WORD_BYTES = WORD_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  cmd_type  cmd,
   input  logic     out_free,
   output logic     idle,
   output logic     emit,
   output item_type item
);

   localparam int CNT_W = $clog2(NUM_REGS + EXTRA_N + 1);
   localparam logic [REG_W-1:0] TOP_REG = REG_W'(NUM_REGS - 1);

   phase_type phase_ff, phase_in;
   logic              is_store_ff, is_store_in;
   logic              after_ff, after_in;
   logic              dec_ff, dec_in;
   logic              modify_ff, modify_in;
   logic [REG_W-1:0]  base_ff, base_in;
   logic [REG_W-1:0]  cur_reg_ff, cur_reg_in;
   logic [CNT_W-1:0]  range_left_ff, range_left_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]  acc_cnt_ff, acc_cnt_in;
   logic [CNT_W-1:0]  total_ff, total_in;

   logic [REG_W-1:0]  hi_c;
   logic [CNT_W-1:0]  range_len;
   logic [IDX_W-1:0]  pick;
   logic              first_en;
   logic [OFS_W-1:0]  offset;
   phase_type         range_done;
   phase_type         extra_done;

   lsmx_offset_unit #(
      .NUM_REGS   (NUM_REGS),
      .WORD_BYTES (WORD_BYTES)
   ) u_offset (
      .first_en (first_en),
      .neg      (dec_ff),
      .count    (acc_cnt_ff),
      .offset   (offset)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         acc_cnt_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         acc_cnt_ff <= acc_cnt_in;
      end
      is_store_ff   <= is_store_in;
      after_ff      <= after_in;
      dec_ff        <= dec_in;
      modify_ff     <= modify_in;
      base_ff       <= base_in;
      cur_reg_ff    <= cur_reg_in;
      range_left_ff <= range_left_in;
      mask_ff       <= mask_in;
      total_ff      <= total_in;
   end

   // extra registers: fp first going up, sp first going down
   always_comb begin
      pick = '0;
      if (dec_ff) begin
         for (int i = EXTRA_N - 1; i >= 0; i--) begin
            if (mask_ff[i]) pick = IDX_W'(i);
         end
      end else begin
         for (int i = 0; i < EXTRA_N; i++) begin
            if (mask_ff[i]) pick = IDX_W'(i);
         end
      end
   end

   always_comb begin
      hi_c = (cmd.last_reg > TOP_REG) ? TOP_REG : cmd.last_reg;
      if (!cmd.range_none && cmd.first_reg <= hi_c) begin
         range_len = CNT_W'(hi_c) - CNT_W'(cmd.first_reg) + CNT_W'(1);
      end else begin
         range_len = '0;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      is_store_in   = is_store_ff;
      after_in      = after_ff;
      dec_in        = dec_ff;
      modify_in     = modify_ff;
      base_in       = base_ff;
      cur_reg_in    = cur_reg_ff;
      range_left_in = range_left_ff;
      mask_in       = mask_ff;
      acc_cnt_in    = acc_cnt_ff;
      total_in      = total_ff;
      emit          = 1'b0;
      first_en      = after_ff && (phase_ff != PH_MODIFY);

      range_done = dec_ff ? (modify_ff ? PH_MODIFY : PH_IDLE) : PH_EXTRA;
      extra_done = dec_ff ? PH_RANGE : (modify_ff ? PH_MODIFY : PH_IDLE);

      item.op_kind     = is_store_ff ? OP_STORE : OP_LOAD;
      item.data_reg    = cur_reg_ff;
      item.addr_reg    = base_ff;
      item.byte_offset = offset;
      item.last        = !modify_ff && (acc_cnt_ff == total_ff - CNT_W'(1));

      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               is_store_in   = cmd.is_store;
               after_in      = cmd.after_mode;
               dec_in        = cmd.decrement;
               modify_in     = cmd.modify_base;
               base_in       = cmd.base_reg;
               cur_reg_in    = cmd.decrement ? hi_c : cmd.first_reg;
               range_left_in = range_len;
               mask_in       = cmd.enable_mask;
               acc_cnt_in    = '0;
               total_in      = range_len + CNT_W'(cmd.enable_mask[0])
                             + CNT_W'(cmd.enable_mask[1])
                             + CNT_W'(cmd.enable_mask[2])
                             + CNT_W'(cmd.enable_mask[3]);
               phase_in      = cmd.decrement ? PH_EXTRA : PH_RANGE;
            end
         end
         PH_RANGE: begin
            if (range_left_ff == '0) begin
               phase_in = range_done;
            end else if (out_free) begin
               emit          = 1'b1;
               cur_reg_in    = dec_ff ? cur_reg_ff - REG_W'(1) : cur_reg_ff + REG_W'(1);
               range_left_in = range_left_ff - CNT_W'(1);
               acc_cnt_in    = acc_cnt_ff + CNT_W'(1);
               if (range_left_ff == CNT_W'(1)) phase_in = range_done;
            end
         end
         PH_EXTRA: begin
            item.data_reg = REG_SP - REG_W'(pick);
            if (mask_ff == '0) begin
               phase_in = extra_done;
            end else if (out_free) begin
               emit       = 1'b1;
               mask_in    = mask_ff & ~(MASK_W'(1) << pick);
               acc_cnt_in = acc_cnt_ff + CNT_W'(1);
               if ((mask_ff & ~(MASK_W'(1) << pick)) == '0) phase_in = extra_done;
            end
         end
         PH_MODIFY: begin
            item.op_kind  = OP_ADD;
            item.data_reg = base_ff;
            item.last     = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign idle = (phase_ff == PH_IDLE);

endmodule
